// ===== src/psrl_pkg.sv =====
// ----------------------------------------------------------------------------
// psrl_pkg: shared types and constants of the per-source rate limiter
// Verdict codes, register indexes, configuration and control structs, and the
// elapsed-time test used by the global and per-source windows.
// ----------------------------------------------------------------------------
`default_nettype none

package psrl_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int COUNT_W     = 16;
  localparam int KEY_W       = 64;
  localparam int VERDICT_W   = 3;
  localparam int OCC_OUT_W   = 5;

  localparam logic [CFG_INDEX_W-1:0] CFG_GLOBAL_LIMIT     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_PER_SOURCE_LIMIT = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_SOURCE_CAPACITY  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_TICKS     = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_RETENTION_TICKS  = 3'd4;

  localparam logic [VERDICT_W-1:0] VERDICT_ADMITTED       = 3'd0;
  localparam logic [VERDICT_W-1:0] VERDICT_GLOBAL_LIMITED = 3'd1;
  localparam logic [VERDICT_W-1:0] VERDICT_TABLE_FULL     = 3'd2;
  localparam logic [VERDICT_W-1:0] VERDICT_SOURCE_LIMITED = 3'd3;
  localparam logic [VERDICT_W-1:0] VERDICT_PURGED         = 3'd4;

  localparam logic ACTION_ADMIT = 1'b0;

  typedef struct packed {
    logic [COUNT_W-1:0] global_limit;
    logic [COUNT_W-1:0] per_source_limit;
    logic [4:0]         source_capacity;
    logic [31:0]        window_ticks;
    logic [31:0]        retention_ticks;
  } cfg_t;

  typedef struct packed {
    logic check;
    logic incr;
  } glob_ctl_t;

  // True when now is not earlier than start and the gap reaches length.
  function automatic logic elapsed(input logic [63:0] start, input logic [63:0] now,
                                   input logic [63:0] length);
    logic [64:0] diff;
    diff = {1'b0, now} - {1'b0, start};
    return !diff[64] && (diff[63:0] >= length);
  endfunction

endpackage

`default_nettype wire

// ===== src/psrl_cfg.sv =====
// ----------------------------------------------------------------------------
// psrl_cfg: configuration register file
// Five registers written through a valid/ready channel; unknown indexes drop.
// ----------------------------------------------------------------------------
`default_nettype none

module psrl_cfg
  import psrl_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_valid,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  output cfg_t                        cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.global_limit     <= 16'd64;
      cfg.per_source_limit <= 16'd8;
      cfg.source_capacity  <= 5'd16;
      cfg.window_ticks     <= 32'd1000;
      cfg.retention_ticks  <= 32'd2000;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_GLOBAL_LIMIT:     cfg.global_limit     <= cfg_data[COUNT_W-1:0];
        CFG_PER_SOURCE_LIMIT: cfg.per_source_limit <= cfg_data[COUNT_W-1:0];
        CFG_SOURCE_CAPACITY:  cfg.source_capacity  <= cfg_data[4:0];
        CFG_WINDOW_TICKS:     cfg.window_ticks     <= cfg_data;
        CFG_RETENTION_TICKS:  cfg.retention_ticks  <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== src/psrl_global.sv =====
// ----------------------------------------------------------------------------
// psrl_global: global fixed-window counter
// Restarts the window on check when it has elapsed and flags the limit.
// ----------------------------------------------------------------------------
`default_nettype none

module psrl_global
  import psrl_pkg::*;
#(
  parameter int TIME_WIDTH = 48
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire cfg_t                  cfg,
  input  wire glob_ctl_t             ctl,
  input  wire logic [TIME_WIDTH-1:0] now,
  output logic                       limited
);

  logic [TIME_WIDTH-1:0] win_start;
  logic [COUNT_W-1:0]    count;
  logic                  win_el;
  logic [COUNT_W-1:0]    count_next;

  always_comb begin
    win_el     = elapsed(64'(win_start), 64'(now), 64'(cfg.window_ticks));
    count_next = win_el ? '0 : count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win_start <= '0;
      count     <= '0;
      limited   <= 1'b0;
    end else if (ctl.check) begin
      if (win_el) begin
        win_start <= now;
      end
      count   <= count_next;
      limited <= count_next >= cfg.global_limit;
    end else if (ctl.incr) begin
      count <= count + 16'd1;
    end
  end

endmodule

`default_nettype wire

// ===== src/per_source_rate_limiter.sv =====
// ----------------------------------------------------------------------------
// per_source_rate_limiter: two-stage fixed-window announcement limiter
// Global window counter, then a per-source table held in a synchronous
// memory that is scanned entry by entry for purge and lookup.
//
//   channel  signals                                     direction
//   item     start, busy, action, source_key, now_ms     in (busy out)
//   result   done, verdict, occupancy                    out
//   config   cfg_valid, cfg_ready, cfg_index, cfg_data   in (ready out)
//
// An item runs from accept through the global check, table scan and decide
// state to the next accept, or ends after the global check if the global
// limit rejects it; the scan reads one entry per cycle via the read port.
// The result beat comes in the first cycle with busy low; a new item may
// start in that cycle.
// Reset clears the valid bits and counters at once; no clearing pass.
// The result beat cannot be stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module per_source_rate_limiter
  import psrl_pkg::*;
#(
  parameter int SOURCES    = 16,
  parameter int TIME_WIDTH = 48
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  output logic                        busy,
  input  wire logic                   action,
  input  wire logic [KEY_W-1:0]       source_key,
  input  wire logic [TIME_WIDTH-1:0]  now_ms,
  output logic                        done,
  output logic [VERDICT_W-1:0]        verdict,
  output logic [OCC_OUT_W-1:0]        occupancy,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int IW = (SOURCES > 1) ? $clog2(SOURCES) : 1;
  localparam int CW = $clog2(SOURCES + 1);
  localparam int TW = TIME_WIDTH;
  localparam int MW = KEY_W + TW + COUNT_W + TW;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_GLOB   = 2'd1;
  localparam logic [1:0] S_SCAN   = 2'd2;
  localparam logic [1:0] S_DECIDE = 2'd3;

  cfg_t      cfg;
  glob_ctl_t glob_ctl;
  logic      glob_limited;

  logic [1:0]          state;
  logic                item_action;
  logic [KEY_W-1:0]    item_key;
  logic [TW-1:0]       item_now;
  logic [CW-1:0]       scan_cnt;
  logic                proc_live;
  logic [IW-1:0]       proc_slot;
  logic [SOURCES-1:0]  valid;
  logic [CW-1:0]       occ;
  logic                found;
  logic [IW-1:0]       found_slot;
  logic [TW-1:0]       hit_ws;
  logic [COUNT_W-1:0]  hit_cnt;
  logic                free_found;
  logic [IW-1:0]       free_slot;

  logic [MW-1:0]       mem [SOURCES];
  logic [MW-1:0]       rd_data;
  logic [KEY_W-1:0]    rd_key;
  logic [TW-1:0]       rd_ws;
  logic [COUNT_W-1:0]  rd_cnt;
  logic [TW-1:0]       rd_last;

  logic                accept;
  logic                scan_end;
  logic                proc_v;
  logic                stale;
  logic                keep;
  logic                hit;

  logic [31:0]         occ_ext;
  logic [31:0]         occ_inc_ext;
  logic [31:0]         cap_eff;
  logic [TW-1:0]       sel_ws;
  logic [COUNT_W-1:0]  sel_cnt;
  logic                cap_full;
  logic                win_el;
  logic [TW-1:0]       new_ws;
  logic [COUNT_W-1:0]  new_cnt;
  logic                src_lim;
  logic [IW-1:0]       wr_slot;
  logic [COUNT_W-1:0]  wr_cnt;
  logic [MW-1:0]       wr_data;
  logic                mem_we;

  psrl_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  psrl_global #(.TIME_WIDTH(TW)) u_global (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .ctl     (glob_ctl),
    .now     (now_ms),
    .limited (glob_limited)
  );

  assign cfg_ready = 1'b1;
  assign busy      = (state != S_IDLE);
  assign accept    = start && !busy;
  assign scan_end  = (scan_cnt == CW'(SOURCES));

  // scan: purge stale entries, look up the key, find the lowest free slot
  always_comb begin
    rd_key  = rd_data[MW-1 -: KEY_W];
    rd_ws   = rd_data[2*TW+COUNT_W-1 -: TW];
    rd_cnt  = rd_data[TW+COUNT_W-1 -: COUNT_W];
    rd_last = rd_data[TW-1:0];
    proc_v  = proc_live && valid[proc_slot];
    stale   = proc_v && elapsed(64'(rd_last), 64'(item_now), 64'(cfg.retention_ticks));
    keep    = proc_v && !stale;
    hit     = keep && (item_action == ACTION_ADMIT) && (rd_key == item_key);
  end

  // decide: pick the entry, check table capacity, roll its window, apply the per-source limit
  always_comb begin
    occ_ext     = 32'(occ);
    occ_inc_ext = 32'(occ) + 32'd1;
    cap_eff     = (32'(cfg.source_capacity) > 32'(SOURCES)) ? 32'(SOURCES)
                                                             : 32'(cfg.source_capacity);
    sel_ws      = found ? hit_ws : item_now;
    sel_cnt     = found ? hit_cnt : '0;
    cap_full    = !found && (!free_found || (occ_ext >= cap_eff));
    win_el      = elapsed(64'(sel_ws), 64'(item_now), 64'(cfg.window_ticks));
    new_ws      = win_el ? item_now : sel_ws;
    new_cnt     = win_el ? '0 : sel_cnt;
    src_lim     = new_cnt >= cfg.per_source_limit;
    wr_slot     = found ? found_slot : free_slot;
    wr_cnt      = src_lim ? new_cnt : new_cnt + 16'd1;
    wr_data     = {item_key, new_ws, wr_cnt, item_now};
    mem_we      = (state == S_DECIDE) && (item_action == ACTION_ADMIT) && !cap_full;
    glob_ctl.check = accept && (action == ACTION_ADMIT);
    glob_ctl.incr  = mem_we && !src_lim;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_slot] <= wr_data;
    end
    rd_data <= mem[scan_cnt[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      done       <= 1'b0;
      valid      <= '0;
      occ        <= '0;
      proc_live  <= 1'b0;
      scan_cnt   <= '0;
      found      <= 1'b0;
      free_found <= 1'b0;
    end else begin
      done      <= 1'b0;
      proc_live <= (state == S_SCAN) && !scan_end;
      proc_slot <= scan_cnt[IW-1:0];

      if (stale) begin
        valid[proc_slot] <= 1'b0;
        occ              <= occ - CW'(1);
      end
      if (hit && !found) begin
        found      <= 1'b1;
        found_slot <= proc_slot;
        hit_ws     <= rd_ws;
        hit_cnt    <= rd_cnt;
      end
      if (proc_live && !keep && !free_found) begin
        free_found <= 1'b1;
        free_slot  <= proc_slot;
      end

      unique case (state)
        S_IDLE: begin
          if (start) begin
            item_action <= action;
            item_key    <= source_key;
            item_now    <= now_ms;
            scan_cnt    <= '0;
            found       <= 1'b0;
            free_found  <= 1'b0;
            state       <= S_GLOB;
          end
        end
        S_GLOB: begin
          if ((item_action == ACTION_ADMIT) && glob_limited) begin
            done      <= 1'b1;
            verdict   <= VERDICT_GLOBAL_LIMITED;
            occupancy <= occ_ext[OCC_OUT_W-1:0];
            state     <= S_IDLE;
          end else begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (scan_end) begin
            state <= S_DECIDE;
          end else begin
            scan_cnt <= scan_cnt + CW'(1);
          end
        end
        S_DECIDE: begin
          done  <= 1'b1;
          state <= S_IDLE;
          priority if (item_action != ACTION_ADMIT) begin
            verdict   <= VERDICT_PURGED;
            occupancy <= occ_ext[OCC_OUT_W-1:0];
          end else if (cap_full) begin
            verdict   <= VERDICT_TABLE_FULL;
            occupancy <= occ_ext[OCC_OUT_W-1:0];
          end else begin
            verdict <= src_lim ? VERDICT_SOURCE_LIMITED : VERDICT_ADMITTED;
            if (found) begin
              occupancy <= occ_ext[OCC_OUT_W-1:0];
            end else begin
              valid[free_slot] <= 1'b1;
              occ              <= occ + CW'(1);
              occupancy        <= occ_inc_ext[OCC_OUT_W-1:0];
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_occ_matches_valid: assert property (@(posedge clk) disable iff (rst)
    32'(occ) == $countones(valid))
    else $error("occupancy counter out of step with valid bits");

  a_occ_bounded: assert property (@(posedge clk) disable iff (rst)
    32'(occ) <= 32'(SOURCES))
    else $error("occupancy above table depth");

  a_done_source: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state) == S_DECIDE || $past(state) == S_GLOB))
    else $error("result beat outside decide or global stage");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("accepted item did not raise busy");

  a_verdict_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (verdict <= VERDICT_PURGED))
    else $error("undefined verdict code");
`endif

endmodule

`default_nettype wire
